@@ hdl/nsmd_pkg.sv @@
// nsmd_pkg: shared constants and types for the sync message decoder.
// No dependencies; imported by every module of the decoder.
`default_nettype none

package nsmd_pkg;

   localparam int ACC_BITS    = 128;                     // message accumulator width
   localparam int OFFSET_BITS = 32;                      // stream byte offset width
   localparam int BP_W        = $clog2(ACC_BITS + 1);    // holds 0..ACC_BITS
   localparam int DATA_BITS   = 6;                       // data part of a trace word
   localparam int BYTE_BITS   = 8;
   localparam int FIXED_END   = 16;                      // end of the fixed header fields
   localparam int FIELD_BITS  = 64;                      // variable field output width
   localparam int RSP_BITS    = 32;                      // offset/length/number width
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [DATA_BITS-1:0] SYNC_TCODE_RESET = 6'h09;

   typedef enum logic [1:0] {
      END_NONE  = 2'd0,
      END_COUNT = 2'd1,
      END_RSVD  = 2'd2,
      END_MSG   = 2'd3
   } end_code_type;

   // One finished message, as handed from the front end to the back end.
   typedef struct packed {
      logic [ACC_BITS-1:0] acc;
      logic [BP_W-1:0]     cnt_end;         // zero: no count end seen
      logic [BP_W-1:0]     msg_end;
      logic [RSP_BITS-1:0] start_offset;
      logic [RSP_BITS-1:0] length_bytes;
      logic [RSP_BITS-1:0] message_number;
      logic                overflowed;
   } msg_rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

@@ hdl/nsmd_front.sv @@
// nsmd_front: accepts trace words, tracks message framing and packs data bits.
// Emits one message record per message end. Depends on nsmd_pkg.
`default_nettype none

module nsmd_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [nsmd_pkg::DATA_BITS-1:0]     csr_wr_data,
   input  logic                               accept,
   input  logic [nsmd_pkg::BYTE_BITS-1:0]     trace_byte,
   output logic                               rec_push,
   output nsmd_pkg::msg_rec_type              rec
);
   import nsmd_pkg::*;

   logic [DATA_BITS-1:0]   sync_tcode_ff;
   logic                   active_ff, active_in;
   logic [ACC_BITS-1:0]    acc_ff, acc_in;
   logic [BP_W-1:0]        bp_ff, bp_in;
   logic [BP_W-1:0]        cnt_end_ff, cnt_end_in;
   logic                   ovf_ff, ovf_in;
   logic [OFFSET_BITS-1:0] byte_offset_ff, byte_offset_in;
   logic [OFFSET_BITS-1:0] msg_start_ff, msg_start_in;
   logic [RSP_BITS-1:0]    sync_count_ff, sync_count_in;

   logic [DATA_BITS-1:0]   data;
   end_code_type           endc;
   logic                   sync_start;
   logic                   act;
   logic                   msg_done;
   logic [ACC_BITS-1:0]    base_acc, packed_acc;
   logic [BP_W-1:0]        base_bp, bp_next;
   logic [BP_W:0]          bp_sum;
   logic [BP_W-1:0]        base_cnt, cnt_next;
   logic                   ovf_next;

   always_comb begin
      data       = trace_byte[BYTE_BITS-1:2];
      endc       = end_code_type'(trace_byte[1:0]);
      sync_start = (data == sync_tcode_ff) && (endc == END_NONE);
      act        = active_ff | sync_start;

      // a sync start discards whatever was open
      base_acc = sync_start ? '0 : acc_ff;
      base_bp  = sync_start ? '0 : bp_ff;
      base_cnt = sync_start ? '0 : cnt_end_ff;

      packed_acc = base_acc | (ACC_BITS'(data) << base_bp);
      bp_sum     = (BP_W+1)'(base_bp) + (BP_W+1)'(DATA_BITS);
      // saturate at the accumulator width, flag the dropped bits
      if (bp_sum > (BP_W+1)'(ACC_BITS)) begin
         bp_next = BP_W'(ACC_BITS);
      end else begin
         bp_next = bp_sum[BP_W-1:0];
      end
      ovf_next = (sync_start ? 1'b0 : ovf_ff) | (bp_sum > (BP_W+1)'(ACC_BITS));
      cnt_next = (endc == END_COUNT && base_cnt == '0) ? bp_next : base_cnt;
      msg_done = act && (endc == END_MSG);
   end

   always_comb begin
      active_in      = active_ff;
      acc_in         = acc_ff;
      bp_in          = bp_ff;
      cnt_end_in     = cnt_end_ff;
      ovf_in         = ovf_ff;
      byte_offset_in = byte_offset_ff;
      msg_start_in   = msg_start_ff;
      sync_count_in  = sync_count_ff;
      if (accept) begin
         byte_offset_in = byte_offset_ff + OFFSET_BITS'(1);
         if (sync_start) begin
            msg_start_in  = byte_offset_ff;
            sync_count_in = sync_count_ff + RSP_BITS'(1);
         end
         if (act) begin
            active_in  = !msg_done;
            acc_in     = msg_done ? '0 : packed_acc;
            bp_in      = msg_done ? '0 : bp_next;
            cnt_end_in = cnt_next;
            ovf_in     = ovf_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_tcode_ff  <= SYNC_TCODE_RESET;
         active_ff      <= 1'b0;
         acc_ff         <= '0;
         bp_ff          <= '0;
         cnt_end_ff     <= '0;
         ovf_ff         <= 1'b0;
         byte_offset_ff <= '0;
         msg_start_ff   <= '0;
         sync_count_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            sync_tcode_ff <= csr_wr_data;
         end
         active_ff      <= active_in;
         acc_ff         <= acc_in;
         bp_ff          <= bp_in;
         cnt_end_ff     <= cnt_end_in;
         ovf_ff         <= ovf_in;
         byte_offset_ff <= byte_offset_in;
         msg_start_ff   <= msg_start_in;
         sync_count_ff  <= sync_count_in;
      end
   end

   // an end word is never a start word, so the start/count registers are current
   always_comb begin
      rec_push           = accept && msg_done;
      rec.acc            = packed_acc;
      rec.cnt_end        = cnt_next;
      rec.msg_end        = bp_next;
      rec.start_offset   = RSP_BITS'(msg_start_ff);
      rec.length_bytes   = RSP_BITS'(OFFSET_BITS'(byte_offset_ff - msg_start_ff
                                                  + OFFSET_BITS'(1)));
      rec.message_number = sync_count_ff;
      rec.overflowed     = ovf_next;
   end

endmodule

`default_nettype wire

@@ hdl/nsmd_queue.sv @@
// nsmd_queue: short record queue between the front end and the back end.
// Depends on nsmd_pkg.
`default_nettype none

module nsmd_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  nsmd_pkg::msg_rec_type       wr_data,
   input  logic                        pop,
   output nsmd_pkg::msg_rec_type       rd_data,
   output nsmd_pkg::queue_status_type  status
);
   import nsmd_pkg::*;

   msg_rec_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   always_comb begin
      status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
      status.empty = (count_ff == '0);
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      rd_data      = slot_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

@@ hdl/nsmd_back.sv @@
// nsmd_back: splits a message record into its fields and holds the result word.
// Depends on nsmd_pkg.
`default_nettype none

module nsmd_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_empty,
   input  nsmd_pkg::msg_rec_type             rec,
   output logic                              q_pop,
   input  logic                              rsp_pop,
   output logic                              rsp_empty,
   output logic [5:0]                        rsp_tcode,
   output logic [3:0]                        rsp_source_id,
   output logic [3:0]                        rsp_sync_reason,
   output logic [1:0]                        rsp_branch_type,
   output logic [nsmd_pkg::FIELD_BITS-1:0]   rsp_instr_count,
   output logic [nsmd_pkg::FIELD_BITS-1:0]   rsp_full_address,
   output logic [nsmd_pkg::RSP_BITS-1:0]     rsp_start_offset,
   output logic [nsmd_pkg::RSP_BITS-1:0]     rsp_length_bytes,
   output logic [nsmd_pkg::RSP_BITS-1:0]     rsp_message_number,
   output logic                              rsp_overflowed
);
   import nsmd_pkg::*;

   typedef struct packed {
      logic [5:0]            tcode;
      logic [3:0]            source_id;
      logic [3:0]            sync_reason;
      logic [1:0]            branch_type;
      logic [FIELD_BITS-1:0] instr_count;
      logic [FIELD_BITS-1:0] full_address;
      logic [RSP_BITS-1:0]   start_offset;
      logic [RSP_BITS-1:0]   length_bytes;
      logic [RSP_BITS-1:0]   message_number;
      logic                  overflowed;
   } rsp_type;

   function automatic logic [FIELD_BITS-1:0] low_mask(input logic [BP_W-1:0] len);
      logic [FIELD_BITS-1:0] m;
      if (len >= BP_W'(FIELD_BITS)) begin
         m = '1;
      end else begin
         m = (FIELD_BITS'(1) << len) - FIELD_BITS'(1);
      end
      return m;
   endfunction

   rsp_type             rsp_ff, rsp_in;
   logic                valid_ff, valid_in;
   logic                load;
   logic [BP_W-1:0]     cnt_raw, cnt_c, msg_c;
   logic [ACC_BITS-1:0] count_shift, addr_shift;

   always_comb begin
      load  = !q_empty && (!valid_ff || rsp_pop);
      q_pop = load;

      // missing count end: count field runs to the message end
      cnt_raw = (rec.cnt_end != '0) ? rec.cnt_end : rec.msg_end;
      cnt_c   = (cnt_raw < BP_W'(FIXED_END)) ? BP_W'(FIXED_END) : cnt_raw;
      msg_c   = (rec.msg_end < BP_W'(FIXED_END)) ? BP_W'(FIXED_END) : rec.msg_end;

      count_shift = rec.acc >> FIXED_END;
      addr_shift  = rec.acc >> cnt_c;

      rsp_in.tcode          = rec.acc[5:0];
      rsp_in.source_id      = rec.acc[9:6];
      rsp_in.sync_reason    = rec.acc[13:10];
      rsp_in.branch_type    = rec.acc[15:14];
      rsp_in.instr_count    = count_shift[FIELD_BITS-1:0]
                              & low_mask(cnt_c - BP_W'(FIXED_END));
      rsp_in.full_address   = addr_shift[FIELD_BITS-1:0] & low_mask(msg_c - cnt_c);
      rsp_in.start_offset   = rec.start_offset;
      rsp_in.length_bytes   = rec.length_bytes;
      rsp_in.message_number = rec.message_number;
      rsp_in.overflowed     = rec.overflowed;

      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_empty          = !valid_ff;
   assign rsp_tcode          = rsp_ff.tcode;
   assign rsp_source_id      = rsp_ff.source_id;
   assign rsp_sync_reason    = rsp_ff.sync_reason;
   assign rsp_branch_type    = rsp_ff.branch_type;
   assign rsp_instr_count    = rsp_ff.instr_count;
   assign rsp_full_address   = rsp_ff.full_address;
   assign rsp_start_offset   = rsp_ff.start_offset;
   assign rsp_length_bytes   = rsp_ff.length_bytes;
   assign rsp_message_number = rsp_ff.message_number;
   assign rsp_overflowed     = rsp_ff.overflowed;

endmodule

`default_nettype wire

@@ hdl/nexus_sync_message_decoder.sv @@
// nexus_sync_message_decoder: top level of the trace sync message decoder.
// Depends on nsmd_pkg, nsmd_front, nsmd_queue and nsmd_back.
//
// Takes one trace word per clock while full is low (bits 7:2 data, bits 1:0
// end code) and returns one decoded result per sync message. A word whose
// data equals the sync code (csr_wr_data, reset 0x09) with end code 0 opens a
// message; data is packed LSB-first into a 128-bit accumulator, the first end
// code 1 marks the end of the instruction count, and end code 3 closes the
// message. Input side: push/full, one word per cycle sustained while full is
// low, and full only rises when two decoded messages are queued behind an
// unread result. Result side: empty/pop; the record of a message is queued at
// the edge that takes its end word and then loads the field-extraction output
// register once that register is empty or popped, and one result can leave
// per clock. The front end does one shift-and-OR per word; the back end does
// the two variable-length field extracts. No clearing pass after reset. Write
// the sync code only while the decoder is idle.
`default_nettype none

module nexus_sync_message_decoder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [nsmd_pkg::DATA_BITS-1:0]    csr_wr_data,
   input  logic                              push,
   output logic                              full,
   input  logic [nsmd_pkg::BYTE_BITS-1:0]    req_trace_byte,
   input  logic                              pop,
   output logic                              empty,
   output logic [5:0]                        rsp_tcode,
   output logic [3:0]                        rsp_source_id,
   output logic [3:0]                        rsp_sync_reason,
   output logic [1:0]                        rsp_branch_type,
   output logic [nsmd_pkg::FIELD_BITS-1:0]   rsp_instr_count,
   output logic [nsmd_pkg::FIELD_BITS-1:0]   rsp_full_address,
   output logic [nsmd_pkg::RSP_BITS-1:0]     rsp_start_offset,
   output logic [nsmd_pkg::RSP_BITS-1:0]     rsp_length_bytes,
   output logic [nsmd_pkg::RSP_BITS-1:0]     rsp_message_number,
   output logic                              rsp_overflowed
);
   import nsmd_pkg::*;

   logic             accept;       // word taken this cycle
   logic             q_push;       // front end closed a message
   logic             q_pop;
   msg_rec_type      rec;          // record leaving the front end
   msg_rec_type      q_head;       // oldest queued record
   queue_status_type q_status;

   // full tracks the record queue; words that close no message could still
   // flow, but holding them keeps the front end's state simple
   assign full   = q_status.full;
   assign accept = push && !full;

   nsmd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .trace_byte  (req_trace_byte),
      .rec_push    (q_push),
      .rec         (rec)
   );

   nsmd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (rec),
      .pop     (q_pop),
      .rd_data (q_head),
      .status  (q_status)
   );

   nsmd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_empty            (q_status.empty),
      .rec                (q_head),
      .q_pop              (q_pop),
      .rsp_pop            (pop),
      .rsp_empty          (empty),
      .rsp_tcode          (rsp_tcode),
      .rsp_source_id      (rsp_source_id),
      .rsp_sync_reason    (rsp_sync_reason),
      .rsp_branch_type    (rsp_branch_type),
      .rsp_instr_count    (rsp_instr_count),
      .rsp_full_address   (rsp_full_address),
      .rsp_start_offset   (rsp_start_offset),
      .rsp_length_bytes   (rsp_length_bytes),
      .rsp_message_number (rsp_message_number),
      .rsp_overflowed     (rsp_overflowed)
   );

   // count end, when seen, never lies past the message end
   assert property (@(posedge clock) disable iff (reset)
      q_push |-> (rec.cnt_end == '0 || rec.cnt_end <= rec.msg_end))
      else $error("count end beyond message end");

   // dropped bits only once the accumulator is saturated
   assert property (@(posedge clock) disable iff (reset)
      (q_push && rec.overflowed) |-> (rec.msg_end == BP_W'(ACC_BITS)))
      else $error("overflow without saturated bit position");

   // a queued record with room at the output must show up as a result
   assert property (@(posedge clock) disable iff (reset)
      (!q_status.empty && (empty || pop)) |=> !empty)
      else $error("queued record not moved to the result register");

endmodule

`default_nettype wire
